>>> sv/lrupr_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lrupr_pkg
// Shared types and constants for the lru page replacement block.
// ----------------------------------------------------------------------------
package lrupr_pkg;

   // sequencer states
   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_FINISH,
      ST_RESP
   } state_type;

   // configuration register
   localparam int unsigned CSR_BITS = 4;
   localparam logic [CSR_BITS-1:0] FRAMES_IN_USE_RESET = 4'd8;

   // fault counter
   localparam int unsigned FAULT_BITS = 32;
   localparam logic [FAULT_BITS-1:0] FAULT_MAX = '1;

   // result frame number width
   localparam int unsigned SLOT_OUT_BITS = 3;

endpackage

>>> sv/lrupr_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lrupr_ram
// Generic single write port, single read port RAM with registered read data.
// ----------------------------------------------------------------------------
module lrupr_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 8
) (
   input  logic                                     clock,
   input  logic                                     wr_en,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                         wr_data,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // write port and registered read
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

>>> sv/lru_page_replacement.sv
`timescale 1ns / 1ps
// A response follows a scan of the first n frames and a finish step, where n is
// the effective frame count (frames_in_use clamped to 1..FRAMES). A new item is
// taken only once the last response is accepted; the scan reads one frame
// a cycle through the single page RAM read port and one page compare unit.
// Reset: synchronous, active high; clears all valid marks, ranks and the fault
// count at once and sets frames_in_use to 8; page contents are left as they are.
// ----------------------------------------------------------------------------
// lru_page_replacement
// LRU page replacement over a small set of frames, one frame examined a cycle.
// ----------------------------------------------------------------------------
module lru_page_replacement #(
   parameter int FRAMES    = 8,
   parameter int PAGE_BITS = 16
) (
   input  logic                               clock,
   input  logic                               reset,
   // configuration
   input  logic                               csr_wr_en,
   input  logic [lrupr_pkg::CSR_BITS-1:0]     csr_wr_data,
   // request channel
   input  logic                               req_valid,
   output logic                               req_ready,
   input  logic [PAGE_BITS-1:0]               req_page_number,
   // response channel
   output logic                               rsp_valid,
   input  logic                               rsp_ready,
   output logic                               rsp_is_hit,
   output logic [lrupr_pkg::SLOT_OUT_BITS-1:0] rsp_frame_slot,
   output logic                               rsp_evict_valid,
   output logic [PAGE_BITS-1:0]               rsp_evicted_page,
   output logic [lrupr_pkg::FAULT_BITS-1:0]   rsp_fault_total
);

   import lrupr_pkg::*;

   localparam int SLOT_BITS = (FRAMES > 1) ? $clog2(FRAMES) : 1;
   localparam int N_BITS    = $clog2(FRAMES + 1);
   localparam int AGE_BITS  = SLOT_BITS + 1;
   localparam int CMP_BITS  = (N_BITS > CSR_BITS) ? N_BITS : CSR_BITS;
   localparam logic [SLOT_BITS-1:0] RANK_MAX   = SLOT_BITS'(FRAMES - 1);
   localparam logic [AGE_BITS-1:0]  AGE_EMPTY  = AGE_BITS'(FRAMES);
   localparam logic [CMP_BITS-1:0]  FRAMES_CMP = CMP_BITS'(FRAMES);

   // control state
   state_type             state_ff, state_in;
   logic [CSR_BITS-1:0]   frames_ff, frames_in;
   logic [N_BITS-1:0]     n_ff, n_in;
   logic [N_BITS-1:0]     issue_ff, issue_in;
   logic                  chk_valid_ff, chk_valid_in;
   logic [N_BITS-1:0]     chk_idx_ff, chk_idx_in;
   logic                  hit_found_ff, hit_found_in;
   logic                  empty_found_ff, empty_found_in;
   logic [FRAMES-1:0]     valid_ff, valid_in;
   logic [SLOT_BITS-1:0]  rank_ff [FRAMES];
   logic [SLOT_BITS-1:0]  rank_in [FRAMES];
   logic [FAULT_BITS-1:0] fault_ff, fault_in;

   // payload state
   logic [PAGE_BITS-1:0]  page_ff, page_in;
   logic [SLOT_BITS-1:0]  hit_slot_ff, hit_slot_in;
   logic [SLOT_BITS-1:0]  hit_rank_ff, hit_rank_in;
   logic [SLOT_BITS-1:0]  empty_slot_ff, empty_slot_in;
   logic [SLOT_BITS-1:0]  best_slot_ff, best_slot_in;
   logic [SLOT_BITS-1:0]  best_rank_ff, best_rank_in;
   logic [PAGE_BITS-1:0]  best_page_ff, best_page_in;
   logic                  out_hit_ff, out_hit_in;
   logic [SLOT_BITS-1:0]  out_slot_ff, out_slot_in;
   logic                  out_evict_ff, out_evict_in;
   logic [PAGE_BITS-1:0]  out_page_ff, out_page_in;

   // page ram ports
   logic                  ram_wr_en;
   logic [SLOT_BITS-1:0]  ram_rd_addr;
   logic [PAGE_BITS-1:0]  ram_rd_data;

   // derived values
   logic [CMP_BITS-1:0]   csr_ext;
   logic [N_BITS-1:0]     active_count;
   logic [SLOT_BITS-1:0]  chk_slot;
   logic [SLOT_BITS-1:0]  sel_slot;
   logic [AGE_BITS-1:0]   old_age;
   logic [SLOT_BITS+SLOT_OUT_BITS-1:0] slot_ext;

   // effective frame count: zero acts as one, too large acts as FRAMES
   assign csr_ext = CMP_BITS'(frames_ff);
   always_comb begin
      if (frames_ff == '0) begin
         active_count = N_BITS'(1);
      end else if (csr_ext > FRAMES_CMP) begin
         active_count = N_BITS'(FRAMES);
      end else begin
         active_count = csr_ext[N_BITS-1:0];
      end
   end

   assign chk_slot = chk_idx_ff[SLOT_BITS-1:0];

   // frame chosen for this item and its age before the access
   always_comb begin
      if (hit_found_ff) begin
         sel_slot = hit_slot_ff;
         old_age  = {1'b0, hit_rank_ff};
      end else if (empty_found_ff) begin
         sel_slot = empty_slot_ff;
         old_age  = AGE_EMPTY;
      end else begin
         sel_slot = best_slot_ff;
         old_age  = {1'b0, best_rank_ff};
      end
   end

   lrupr_ram #(
      .WIDTH (PAGE_BITS),
      .DEPTH (FRAMES)
   ) u_page_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (sel_slot),
      .wr_data (page_ff),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   // sequencer: next state and datapath
   always_comb begin
      state_in       = state_ff;
      frames_in      = frames_ff;
      n_in           = n_ff;
      issue_in       = issue_ff;
      chk_valid_in   = chk_valid_ff;
      chk_idx_in     = chk_idx_ff;
      hit_found_in   = hit_found_ff;
      empty_found_in = empty_found_ff;
      valid_in       = valid_ff;
      rank_in        = rank_ff;
      fault_in       = fault_ff;
      page_in        = page_ff;
      hit_slot_in    = hit_slot_ff;
      hit_rank_in    = hit_rank_ff;
      empty_slot_in  = empty_slot_ff;
      best_slot_in   = best_slot_ff;
      best_rank_in   = best_rank_ff;
      best_page_in   = best_page_ff;
      out_hit_in     = out_hit_ff;
      out_slot_in    = out_slot_ff;
      out_evict_in   = out_evict_ff;
      out_page_in    = out_page_ff;
      ram_wr_en      = 1'b0;
      ram_rd_addr    = issue_ff[SLOT_BITS-1:0];

      if (csr_wr_en) begin
         frames_in = csr_wr_data;
      end

      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               page_in        = req_page_number;
               n_in           = active_count;
               issue_in       = '0;
               chk_valid_in   = 1'b0;
               hit_found_in   = 1'b0;
               empty_found_in = 1'b0;
               state_in       = ST_SCAN;
            end
         end

         ST_SCAN: begin
            // issue one ram read a cycle, data is checked the cycle after
            if (issue_ff < n_ff) begin
               issue_in     = issue_ff + N_BITS'(1);
               chk_valid_in = 1'b1;
               chk_idx_in   = issue_ff;
            end else begin
               chk_valid_in = 1'b0;
            end
            if (chk_valid_ff) begin
               // first resident match
               if (!hit_found_ff && valid_ff[chk_slot] && ram_rd_data == page_ff) begin
                  hit_found_in = 1'b1;
                  hit_slot_in  = chk_slot;
                  hit_rank_in  = rank_ff[chk_slot];
               end
               // lowest empty frame
               if (!empty_found_ff && !valid_ff[chk_slot]) begin
                  empty_found_in = 1'b1;
                  empty_slot_in  = chk_slot;
               end
               // oldest frame, lowest number on ties
               if (chk_idx_ff == '0 || rank_ff[chk_slot] > best_rank_ff) begin
                  best_slot_in = chk_slot;
                  best_rank_in = rank_ff[chk_slot];
                  best_page_in = ram_rd_data;
               end
               if (chk_idx_ff == n_ff - N_BITS'(1)) begin
                  state_in = ST_FINISH;
               end
            end
         end

         ST_FINISH: begin
            // age every valid participating frame younger than the one touched
            for (int k = 0; k < FRAMES; k++) begin
               if (N_BITS'(k) < n_ff && SLOT_BITS'(k) != sel_slot && valid_ff[k] &&
                   {1'b0, rank_ff[k]} < old_age && rank_ff[k] != RANK_MAX) begin
                  rank_in[k] = rank_ff[k] + SLOT_BITS'(1);
               end
            end
            rank_in[sel_slot]  = '0;
            valid_in[sel_slot] = 1'b1;
            if (!hit_found_ff) begin
               ram_wr_en = 1'b1;
               if (fault_ff != FAULT_MAX) begin
                  fault_in = fault_ff + FAULT_BITS'(1);
               end
            end
            out_hit_in   = hit_found_ff;
            out_slot_in  = sel_slot;
            out_evict_in = !hit_found_ff && !empty_found_ff;
            out_page_in  = (!hit_found_ff && !empty_found_ff) ? best_page_ff : '0;
            state_in     = ST_RESP;
         end

         ST_RESP: begin
            if (rsp_ready) begin
               state_in = ST_IDLE;
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= ST_IDLE;
         frames_ff      <= FRAMES_IN_USE_RESET;
         n_ff           <= '0;
         issue_ff       <= '0;
         chk_valid_ff   <= 1'b0;
         chk_idx_ff     <= '0;
         hit_found_ff   <= 1'b0;
         empty_found_ff <= 1'b0;
         valid_ff       <= '0;
         fault_ff       <= '0;
         for (int k = 0; k < FRAMES; k++) begin
            rank_ff[k] <= '0;
         end
      end else begin
         state_ff       <= state_in;
         frames_ff      <= frames_in;
         n_ff           <= n_in;
         issue_ff       <= issue_in;
         chk_valid_ff   <= chk_valid_in;
         chk_idx_ff     <= chk_idx_in;
         hit_found_ff   <= hit_found_in;
         empty_found_ff <= empty_found_in;
         valid_ff       <= valid_in;
         fault_ff       <= fault_in;
         rank_ff        <= rank_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      page_ff       <= page_in;
      hit_slot_ff   <= hit_slot_in;
      hit_rank_ff   <= hit_rank_in;
      empty_slot_ff <= empty_slot_in;
      best_slot_ff  <= best_slot_in;
      best_rank_ff  <= best_rank_in;
      best_page_ff  <= best_page_in;
      out_hit_ff    <= out_hit_in;
      out_slot_ff   <= out_slot_in;
      out_evict_ff  <= out_evict_in;
      out_page_ff   <= out_page_in;
   end

   // ports
   assign slot_ext         = {{SLOT_OUT_BITS{1'b0}}, out_slot_ff};
   assign req_ready        = (state_ff == ST_IDLE);
   assign rsp_valid        = (state_ff == ST_RESP);
   assign rsp_is_hit       = out_hit_ff;
   assign rsp_frame_slot   = slot_ext[SLOT_OUT_BITS-1:0];
   assign rsp_evict_valid  = out_evict_ff;
   assign rsp_evicted_page = out_page_ff;
   assign rsp_fault_total  = fault_ff;

   // checks
   a_no_overlap: assert property (@(posedge clock) disable iff (reset)
      !(req_ready && rsp_valid))
      else $error("request taken while a response is pending");

   a_hit_no_evict: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !(rsp_is_hit && rsp_evict_valid))
      else $error("hit reported with an eviction");

   a_fault_monotonic: assert property (@(posedge clock) disable iff (reset)
      !$past(reset) |-> fault_ff >= $past(fault_ff))
      else $error("fault count went down");

   a_hit_keeps_count: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_FINISH && hit_found_ff) |=> $stable(fault_ff))
      else $error("fault count moved on a hit");

endmodule

>>> dv/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for lru_page_replacement. A short directed walk covers
// page extremes, hits, fills, evictions, frame counts of 0, 1, 4, 8, 9 and 15,
// pages that stay resident outside a lowered frame count, and ties for the
// oldest frame. Random phases follow, each with its own frame count and mostly
// pages from a small working set, so that hits and evictions are frequent.
// Every result is checked against a cycle-free predictor of the frame table.
// ----------------------------------------------------------------------------
module tb;

   import lrupr_pkg::*;

   localparam int FRAMES          = 8;
   localparam int PAGE_BITS       = 16;
   localparam int POOL_SIZE       = 12;
   localparam int PHASES          = 12;
   localparam int ITEMS_PER_PHASE = 150;
   localparam int DRAIN_CYCLES    = 20;
   localparam int CYCLE_LIMIT     = 1_000_000;
   localparam int REPORT_LIMIT    = 10;

   // one result item, fields in port order
   typedef struct packed {
      logic                     is_hit;
      logic [SLOT_OUT_BITS-1:0] frame_slot;
      logic                     evict_valid;
      logic [PAGE_BITS-1:0]     evicted_page;
      logic [FAULT_BITS-1:0]    fault_total;
   } page_result_type;

   // one row of the directed walk; result is used only when typed is set
   typedef struct packed {
      logic                 csr_wr;
      logic [CSR_BITS-1:0]  csr_value;
      logic [PAGE_BITS-1:0] page;
      logic                 typed;
      page_result_type      result;
   } page_row_type;

   localparam page_result_type UNTYPED = '0;

   localparam page_row_type DIRECTED_ROWS [23] = '{
      // fills after reset, one hit in between
      '{1'b0, 4'd0,  16'h0000, 1'b1, '{1'b0, 3'd0, 1'b0, 16'h0000, 32'd1}},
      '{1'b0, 4'd0,  16'hFFFF, 1'b1, '{1'b0, 3'd1, 1'b0, 16'h0000, 32'd2}},
      '{1'b0, 4'd0,  16'h0000, 1'b1, '{1'b1, 3'd0, 1'b0, 16'h0000, 32'd2}},
      '{1'b0, 4'd0,  16'h0001, 1'b1, '{1'b0, 3'd2, 1'b0, 16'h0000, 32'd3}},
      '{1'b0, 4'd0,  16'h8000, 1'b1, '{1'b0, 3'd3, 1'b0, 16'h0000, 32'd4}},
      '{1'b0, 4'd0,  16'h7FFF, 1'b1, '{1'b0, 3'd4, 1'b0, 16'h0000, 32'd5}},
      '{1'b0, 4'd0,  16'h5555, 1'b1, '{1'b0, 3'd5, 1'b0, 16'h0000, 32'd6}},
      '{1'b0, 4'd0,  16'hAAAA, 1'b1, '{1'b0, 3'd6, 1'b0, 16'h0000, 32'd7}},
      '{1'b0, 4'd0,  16'h1234, 1'b1, '{1'b0, 3'd7, 1'b0, 16'h0000, 32'd8}},
      // count 0 acts as one frame: page in frame 7 misses and lands in frame 0
      '{1'b1, 4'd0,  16'h1234, 1'b1, '{1'b0, 3'd0, 1'b1, 16'h0000, 32'd9}},
      // count 15 acts as eight: duplicate page hits the lowest frame
      '{1'b1, 4'd15, 16'h1234, 1'b1, '{1'b1, 3'd0, 1'b0, 16'h0000, 32'd9}},
      '{1'b0, 4'd0,  16'hFFFF, 1'b1, '{1'b1, 3'd1, 1'b0, 16'h0000, 32'd9}},
      // age only the low frames, then widen again to build equal ages
      '{1'b1, 4'd4,  16'h4321, 1'b0, UNTYPED},
      '{1'b1, 4'd8,  16'h00FF, 1'b0, UNTYPED},
      '{1'b0, 4'd0,  16'h1111, 1'b0, UNTYPED},
      '{1'b0, 4'd0,  16'h2222, 1'b0, UNTYPED},
      '{1'b0, 4'd0,  16'h3333, 1'b0, UNTYPED},
      '{1'b0, 4'd0,  16'h4444, 1'b0, UNTYPED},
      '{1'b0, 4'd0,  16'h6666, 1'b0, UNTYPED},
      '{1'b0, 4'd0,  16'h7777, 1'b0, UNTYPED},
      '{1'b1, 4'd9,  16'h0F0F, 1'b0, UNTYPED},
      '{1'b1, 4'd1,  16'hF0F0, 1'b0, UNTYPED},
      '{1'b0, 4'd0,  16'h0F0F, 1'b0, UNTYPED}
   };

   // frame count of each random phase
   localparam logic [CSR_BITS-1:0] PHASE_FRAMES [PHASES] = '{
      4'd8, 4'd3, 4'd0, 4'd15, 4'd1, 4'd6, 4'd9, 4'd2, 4'd5, 4'd8, 4'd7, 4'd4
   };

   logic                     clock            = 1'b0;
   logic                     reset            = 1'b1;
   logic                     csr_wr_en        = 1'b0;
   logic [CSR_BITS-1:0]      csr_wr_data      = '0;
   logic                     req_valid        = 1'b0;
   logic                     req_ready;
   logic [PAGE_BITS-1:0]     req_page_number  = '0;
   logic                     rsp_valid;
   logic                     rsp_ready        = 1'b0;
   logic                     rsp_is_hit;
   logic [SLOT_OUT_BITS-1:0] rsp_frame_slot;
   logic                     rsp_evict_valid;
   logic [PAGE_BITS-1:0]     rsp_evicted_page;
   logic [FAULT_BITS-1:0]    rsp_fault_total;

   // predicted frame table
   logic [PAGE_BITS-1:0]  frame_page  [FRAMES];
   logic                  frame_valid [FRAMES];
   int                    frame_age   [FRAMES];
   logic [FAULT_BITS-1:0] fault_count;
   logic [CSR_BITS-1:0]   frames_cfg;

   page_result_type pending_results [$];

   logic [PAGE_BITS-1:0] page_pool [POOL_SIZE];

   int send_idle_pct = 24;
   int recv_idle_pct = 87;
   int fail_count    = 0;
   int items_sent    = 0;
   int results_seen  = 0;
   int hits_seen     = 0;
   int evicts_seen   = 0;
   int csr_writes    = 0;
   int cycle_count   = 0;

   lru_page_replacement #(
      .FRAMES    (FRAMES),
      .PAGE_BITS (PAGE_BITS)
   ) DUT (
      .clock            (clock),
      .reset            (reset),
      .csr_wr_en        (csr_wr_en),
      .csr_wr_data      (csr_wr_data),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_page_number  (req_page_number),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_is_hit       (rsp_is_hit),
      .rsp_frame_slot   (rsp_frame_slot),
      .rsp_evict_valid  (rsp_evict_valid),
      .rsp_evicted_page (rsp_evicted_page),
      .rsp_fault_total  (rsp_fault_total)
   );

   // clock
   always #1 clock = ~clock;

   // run limit
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("timeout after %0d cycles, %0d results pending",
                  cycle_count, pending_results.size());
         $display("Verification failed");
         $finish;
      end
   end

   // make frame f the newest; younger participating frames grow one older
   function automatic void age_frames(input int n, input int f, input int old_age);
      for (int k = 0; k < n; k++) begin
         if (k != f && frame_valid[k] && frame_age[k] < old_age && frame_age[k] < FRAMES - 1)
            frame_age[k]++;
      end
      frame_age[f] = 0;
   endfunction

   // lookup, fill or replace one page and return the result item
   function automatic page_result_type predict_access(input logic [PAGE_BITS-1:0] page);
      int              n;
      int              slot;
      bit              hit;
      bit              found_empty;
      page_result_type r;
      n = (frames_cfg == 0) ? 1 : ((frames_cfg > FRAMES) ? FRAMES : int'(frames_cfg));
      slot = 0;
      hit = 1'b0;
      found_empty = 1'b0;
      r = '0;
      for (int k = 0; k < n; k++) begin
         if (!hit && frame_valid[k] && frame_page[k] == page) begin
            hit = 1'b1;
            slot = k;
         end
      end
      if (hit) begin
         age_frames(n, slot, frame_age[slot]);
      end else begin
         if (fault_count != FAULT_MAX)
            fault_count++;
         for (int k = 0; k < n; k++) begin
            if (!found_empty && !frame_valid[k]) begin
               found_empty = 1'b1;
               slot = k;
            end
         end
         if (found_empty) begin
            age_frames(n, slot, FRAMES);
            frame_valid[slot] = 1'b1;
         end else begin
            // oldest frame, lowest number on a tie
            slot = 0;
            for (int k = 1; k < n; k++) begin
               if (frame_age[k] > frame_age[slot])
                  slot = k;
            end
            r.evict_valid = 1'b1;
            r.evicted_page = frame_page[slot];
            age_frames(n, slot, frame_age[slot]);
         end
         frame_page[slot] = page;
      end
      r.is_hit = hit;
      r.frame_slot = 3'(slot);
      r.fault_total = fault_count;
      return r;
   endfunction

   // present one page item and record its expected result on acceptance
   task automatic push_page(input logic [PAGE_BITS-1:0] page, input logic typed,
                            input page_result_type typed_result);
      page_result_type predicted;
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid <= 1'b1;
      req_page_number <= page;
      do
         @(posedge clock);
      while (!req_ready);
      predicted = predict_access(page);
      pending_results.push_back(typed ? typed_result : predicted);
      items_sent++;
      if (predicted.is_hit)
         hits_seen++;
      if (predicted.evict_valid)
         evicts_seen++;
      @(negedge clock);
   endtask

   // stop sending and wait for every outstanding result
   task automatic wait_drain();
      req_valid <= 1'b0;
      while (pending_results.size() != 0)
         @(posedge clock);
      @(negedge clock);
   endtask

   // single-cycle register write while the block is idle
   task automatic write_frames(input logic [CSR_BITS-1:0] value);
      csr_wr_en <= 1'b1;
      csr_wr_data <= value;
      @(negedge clock);
      csr_wr_en <= 1'b0;
      frames_cfg = value;
      csr_writes++;
   endtask

   // result side stalls
   always @(negedge clock) begin
      rsp_ready <= ($urandom_range(99) >= recv_idle_pct);
   end

   // result checker
   always @(posedge clock) begin
      page_result_type got;
      page_result_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         got = '{rsp_is_hit, rsp_frame_slot, rsp_evict_valid, rsp_evicted_page,
                 rsp_fault_total};
         if (pending_results.size() == 0) begin
            if (fail_count < REPORT_LIMIT)
               $display("%0t: result item with nothing pending: hit=%0d slot=%0d",
                        $realtime, got.is_hit, got.frame_slot);
            fail_count++;
         end else begin
            want = pending_results.pop_front();
            results_seen++;
            if (got !== want) begin
               if (fail_count < REPORT_LIMIT) begin
                  $display("%0t: mismatch on result %0d", $realtime, results_seen);
                  $display("   expected hit=%0d slot=%0d evict=%0d page=%h faults=%0d",
                           want.is_hit, want.frame_slot, want.evict_valid,
                           want.evicted_page, want.fault_total);
                  $display("   actual   hit=%0d slot=%0d evict=%0d page=%h faults=%0d",
                           got.is_hit, got.frame_slot, got.evict_valid,
                           got.evicted_page, got.fault_total);
               end
               fail_count++;
            end
         end
      end
   end

   // stimulus
   initial begin
      logic [PAGE_BITS-1:0] page;
      int                   n;
      int                   span;

      // predictor reset state
      for (int k = 0; k < FRAMES; k++) begin
         frame_page[k] = '0;
         frame_valid[k] = 1'b0;
         frame_age[k] = 0;
      end
      fault_count = '0;
      frames_cfg = FRAMES_IN_USE_RESET;
      for (int k = 0; k < POOL_SIZE; k++)
         page_pool[k] = PAGE_BITS'($urandom);

      repeat (11) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // directed walk
      foreach (DIRECTED_ROWS[i]) begin
         if (DIRECTED_ROWS[i].csr_wr) begin
            wait_drain();
            write_frames(DIRECTED_ROWS[i].csr_value);
         end
         push_page(DIRECTED_ROWS[i].page, DIRECTED_ROWS[i].typed, DIRECTED_ROWS[i].result);
      end

      // random phases: working-set pages with some fully random noise
      for (int p = 0; p < PHASES; p++) begin
         wait_drain();
         write_frames(PHASE_FRAMES[p]);
         case (p / 4)
            0: begin
               send_idle_pct = 24;
               recv_idle_pct = 87;
            end
            1: begin
               send_idle_pct = 87;
               recv_idle_pct = 24;
            end
            default: begin
               send_idle_pct = 0;
               recv_idle_pct = 0;
            end
         endcase
         // refresh part of the working set
         repeat (3)
            page_pool[$urandom_range(POOL_SIZE - 1)] = PAGE_BITS'($urandom);
         n = (frames_cfg == 0) ? 1 : ((frames_cfg > FRAMES) ? FRAMES : int'(frames_cfg));
         span = (n + 2 < POOL_SIZE) ? n + 2 : POOL_SIZE;
         for (int i = 0; i < ITEMS_PER_PHASE; i++) begin
            if ($urandom_range(99) < 85)
               page = page_pool[$urandom_range(span - 1)];
            else
               page = PAGE_BITS'($urandom);
            push_page(page, 1'b0, UNTYPED);
         end
      end

      wait_drain();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (pending_results.size() != 0) begin
         $display("%0d result items never arrived", pending_results.size());
         fail_count++;
      end

      $display("covered %0d page items: %0d hits, %0d faults, %0d evictions",
               items_sent, hits_seen, fault_count, evicts_seen);
      $display("%0d frame count writes, counts 0 to 15 with idle and stall mixes",
               csr_writes);
      if (fail_count == 0)
         $display("Verification passed");
      else
         $display("Verification failed");
      $finish;
   end

endmodule
